/* rtl/core/ufe_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ufe_pkg
// Shared constants and types of the URL file extension extractor.
// ----------------------------------------------------------------------------
package ufe_pkg;

	// default and hard limit of extension characters
	localparam int MAX_EXT_DEFAULT = 10;
	localparam int STORE_DEPTH     = 10;
	localparam int EXT_LEN_W       = 4;

	// delimiters, already lower-cased domain
	localparam logic [7:0] CHR_SLASH = 8'h2F;
	localparam logic [7:0] CHR_QUERY = 8'h3F;
	localparam logic [7:0] CHR_HASH  = 8'h23;
	localparam logic [7:0] CHR_DOT   = 8'h2E;

	// control broadcast from the parser to the character cells
	typedef struct packed {
		logic       clr;
		logic       wr;
		logic       fin;
		logic [7:0] chr;
	} ufe_cell_ctl_t;

endpackage

/* rtl/core/url_file_extension_extractor_core.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// url_file_extension_extractor_core
// Streams URL bytes and reports the file extension of the path.
// ----------------------------------------------------------------------------
// Input channel: one URL byte per word (in_byte, end_of_url) on
// byte_valid / byte_stall. end_of_url marks the final byte of a URL.
// Output channel: one word per URL (found, ext_len, ext_chars_low,
// ext_chars_high) on result_valid / result_stall.
// Throughput: one byte per cycle while byte_stall is low, set by the
// parser and the row of character cells that takes one write a cycle.
// Result: registered in the output register when the last byte is taken, or in the skid register while that is held.
// Stalls: a result the receiver has not taken is held in the output register;
// one more result fits a skid register, and byte_stall rises only while
// that skid register is full.
// Reset: parser goes back to looking for the first slash, all cells clear,
// both result registers empty. Bytes are accepted right from reset.
// ----------------------------------------------------------------------------
module url_file_extension_extractor_core #(
	parameter int MAX_EXT_CHARS = ufe_pkg::MAX_EXT_DEFAULT
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          byte_valid,
	output logic                          byte_stall,
	input  logic [7:0]                    in_byte,
	input  logic                          end_of_url,
	output logic                          result_valid,
	input  logic                          result_stall,
	output logic                          found,
	output logic [ufe_pkg::EXT_LEN_W-1:0] ext_len,
	output logic [63:0]                   ext_chars_low,
	output logic [15:0]                   ext_chars_high
);
	import ufe_pkg::*;

	localparam int CHR_W = 8 * STORE_DEPTH;

	ufe_cell_ctl_t          ctl;
	logic                   acc;
	logic                   res_found;
	logic [EXT_LEN_W-1:0]   res_len;
	logic [MAX_EXT_CHARS:0] tok;
	logic [CHR_W-1:0]       chr_all;
	logic [CHR_W-1:0]       res_chr;
	logic                   res_new;

	logic                   out_vld_q, skid_vld_q;
	logic                   out_found_q, skid_found_q;
	logic [EXT_LEN_W-1:0]   out_len_q, skid_len_q;
	logic [CHR_W-1:0]       out_chr_q, skid_chr_q;

	assign byte_stall = skid_vld_q;
	assign acc        = byte_valid && !byte_stall;
	assign res_new    = acc && end_of_url;

	ufe_ctrl #(
		.MAX_EXT_CHARS(MAX_EXT_CHARS)
	) u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.acc       (acc),
		.in_byte   (in_byte),
		.end_of_url(end_of_url),
		.ctl       (ctl),
		.res_found (res_found),
		.res_len   (res_len)
	);

	// row of character cells, write token enters at cell zero
	assign tok[0] = 1'b0;
	genvar gi;
	generate
		for (gi = 0; gi < STORE_DEPTH; gi++) begin : g_slot
			if (gi < MAX_EXT_CHARS) begin : g_cell
				ufe_cell u_cell (
					.clk    (clk),
					.arst_n (arst_n),
					.head   (gi == 0),
					.ctl    (ctl),
					.tok_in (tok[gi]),
					.tok_out(tok[gi+1]),
					.chr_nxt(chr_all[8*gi +: 8])
				);
			end else begin : g_pad
				assign chr_all[8*gi +: 8] = 8'h00;
			end
		end
	endgenerate

	assign res_chr = res_found ? chr_all : '0;

	// output register with one skid entry
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_vld_q  <= 1'b0;
			skid_vld_q <= 1'b0;
		end else if (!out_vld_q || !result_stall) begin
			if (skid_vld_q) begin
				out_vld_q  <= 1'b1;
				skid_vld_q <= 1'b0;
			end else begin
				out_vld_q <= res_new;
			end
		end else if (res_new) begin
			skid_vld_q <= 1'b1;
		end
	end

	// result payload
	always_ff @(posedge clk) begin
		if (!out_vld_q || !result_stall) begin
			if (skid_vld_q) begin
				out_found_q <= skid_found_q;
				out_len_q   <= skid_len_q;
				out_chr_q   <= skid_chr_q;
			end else if (res_new) begin
				out_found_q <= res_found;
				out_len_q   <= res_len;
				out_chr_q   <= res_chr;
			end
		end else if (res_new) begin
			skid_found_q <= res_found;
			skid_len_q   <= res_len;
			skid_chr_q   <= res_chr;
		end
	end

	assign result_valid   = out_vld_q;
	assign found          = out_found_q;
	assign ext_len        = out_len_q;
	assign ext_chars_low  = out_chr_q[63:0];
	assign ext_chars_high = out_chr_q[CHR_W-1:64];

	// skid entry is only used behind a full output register
	a_skid_behind_out: assert property (@(posedge clk) disable iff (!arst_n)
		skid_vld_q |-> out_vld_q)
		else $error("skid register holds a word while the output is empty");

	// a found extension has a legal length
	a_found_len: assert property (@(posedge clk) disable iff (!arst_n)
		(result_valid && found) |-> (ext_len != '0 &&
			ext_len <= EXT_LEN_W'(MAX_EXT_CHARS)))
		else $error("found extension with bad length");

	// not found reports an all-zero payload
	a_not_found_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(result_valid && !found) |-> (ext_len == '0 && ext_chars_low == '0 &&
			ext_chars_high == '0))
		else $error("not-found result carries data");

endmodule

/* rtl/core/ufe_cell.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ufe_cell
// One extension character slot; a write token walks down the row of cells.
// ----------------------------------------------------------------------------
module ufe_cell (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  head,
	input  ufe_pkg::ufe_cell_ctl_t ctl,
	input  logic                  tok_in,
	output logic                  tok_out,
	output logic [7:0]            chr_nxt
);
	import ufe_pkg::*;

	logic       tok_q;
	logic [7:0] chr_q;

	// value after this word, before the end-of-url clear
	always_comb begin
		if (ctl.clr) begin
			chr_nxt = 8'h00;
		end else if (ctl.wr && tok_q) begin
			chr_nxt = ctl.chr;
		end else begin
			chr_nxt = chr_q;
		end
	end

	assign tok_out = tok_q;

	// slot storage and token hand-off
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tok_q <= head;
			chr_q <= 8'h00;
		end else if (ctl.fin || ctl.clr) begin
			tok_q <= head;
			chr_q <= 8'h00;
		end else if (ctl.wr) begin
			tok_q <= tok_in;
			chr_q <= chr_nxt;
		end
	end

endmodule

/* rtl/core/ufe_ctrl.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ufe_ctrl
// Path parser: phase tracking, filename and dot flags, extension count.
// ----------------------------------------------------------------------------
module ufe_ctrl #(
	parameter int MAX_EXT_CHARS = ufe_pkg::MAX_EXT_DEFAULT
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          acc,
	input  logic [7:0]                    in_byte,
	input  logic                          end_of_url,
	output ufe_pkg::ufe_cell_ctl_t         ctl,
	output logic                          res_found,
	output logic [ufe_pkg::EXT_LEN_W-1:0] res_len
);
	import ufe_pkg::*;

	localparam int CNT_W = $clog2(MAX_EXT_CHARS + 2);
	localparam logic [CNT_W-1:0] CNT_MAX  = CNT_W'(MAX_EXT_CHARS);
	localparam logic [CNT_W-1:0] CNT_OVER = CNT_W'(MAX_EXT_CHARS + 1);

	typedef enum logic [2:0] {
		PH_SEEK_FIRST,
		PH_AFTER_FIRST,
		PH_SEEK_SECOND,
		PH_IN_PATH,
		PH_PATH_DONE
	} phase_t;

	phase_t           phase_q, phase_n;
	logic             nonempty_q, nonempty_n;
	logic             prev_dot_q, prev_dot_n;
	logic             dot_seen_q, dot_seen_n;
	logic             dot_ok_q, dot_ok_n;
	logic             alnum_q, alnum_n;
	logic [CNT_W-1:0] cnt_q, cnt_n;
	logic [7:0]       c_lc;
	logic             is_slash, is_dot, is_term, is_alnum;
	logic             path_en, clr_fn, wr;

	// lower-case only 'A'..'Z'
	assign c_lc     = (in_byte >= 8'h41 && in_byte <= 8'h5A) ? (in_byte | 8'h20) : in_byte;
	assign is_slash = (c_lc == CHR_SLASH);
	assign is_dot   = (c_lc == CHR_DOT);
	assign is_term  = (c_lc == CHR_QUERY) || (c_lc == CHR_HASH);
	assign is_alnum = (c_lc >= 8'h30 && c_lc <= 8'h39) || (c_lc >= 8'h61 && c_lc <= 8'h7A);
	assign path_en  = (phase_q == PH_IN_PATH) || ((phase_q == PH_AFTER_FIRST) && !is_slash);

	// next state for the current word
	always_comb begin
		phase_n    = phase_q;
		nonempty_n = nonempty_q;
		prev_dot_n = prev_dot_q;
		dot_seen_n = dot_seen_q;
		dot_ok_n   = dot_ok_q;
		alnum_n    = alnum_q;
		cnt_n      = cnt_q;
		clr_fn     = 1'b0;
		wr         = 1'b0;

		unique case (phase_q)
			PH_SEEK_FIRST: begin
				if (is_slash) phase_n = PH_AFTER_FIRST;
			end
			PH_AFTER_FIRST: begin
				phase_n = is_slash ? PH_SEEK_SECOND : PH_IN_PATH;
			end
			PH_SEEK_SECOND: begin
				if (is_slash) begin
					phase_n = PH_IN_PATH;
					clr_fn  = 1'b1;
				end
			end
			PH_IN_PATH, PH_PATH_DONE: begin
			end
			default: begin
			end
		endcase

		// byte inside the path
		if (path_en) begin
			priority if (is_term) begin
				phase_n = PH_PATH_DONE;
			end else if (is_slash) begin
				clr_fn = 1'b1;
			end else if (is_dot) begin
				dot_ok_n   = nonempty_q && !prev_dot_q;
				dot_seen_n = 1'b1;
				cnt_n      = '0;
				alnum_n    = 1'b1;
				prev_dot_n = 1'b1;
				nonempty_n = 1'b1;
			end else begin
				if (dot_seen_q) begin
					if (cnt_q < CNT_MAX) begin
						wr    = 1'b1;
						cnt_n = cnt_q + 1'b1;
					end else begin
						cnt_n = CNT_OVER;
					end
					if (!is_alnum) alnum_n = 1'b0;
				end
				prev_dot_n = 1'b0;
				nonempty_n = 1'b1;
			end
		end

		// new filename segment
		if (clr_fn) begin
			nonempty_n = 1'b0;
			prev_dot_n = 1'b0;
			dot_seen_n = 1'b0;
			dot_ok_n   = 1'b0;
			cnt_n      = '0;
			alnum_n    = 1'b1;
		end
	end

	// cell broadcast
	assign ctl.clr = acc && (clr_fn || (path_en && is_dot && !is_term));
	assign ctl.wr  = acc && wr;
	assign ctl.fin = acc && end_of_url;
	assign ctl.chr = c_lc;

	// verdict on the state after this word
	assign res_found = dot_seen_n && dot_ok_n && alnum_n && (cnt_n != '0) && (cnt_n <= CNT_MAX);
	assign res_len   = res_found ? EXT_LEN_W'(cnt_n) : '0;

	// parser state, back to reset after the last word of a url
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q    <= PH_SEEK_FIRST;
			nonempty_q <= 1'b0;
			prev_dot_q <= 1'b0;
			dot_seen_q <= 1'b0;
			dot_ok_q   <= 1'b0;
			alnum_q    <= 1'b1;
			cnt_q      <= '0;
		end else if (acc) begin
			if (end_of_url) begin
				phase_q    <= PH_SEEK_FIRST;
				nonempty_q <= 1'b0;
				prev_dot_q <= 1'b0;
				dot_seen_q <= 1'b0;
				dot_ok_q   <= 1'b0;
				alnum_q    <= 1'b1;
				cnt_q      <= '0;
			end else begin
				phase_q    <= phase_n;
				nonempty_q <= nonempty_n;
				prev_dot_q <= prev_dot_n;
				dot_seen_q <= dot_seen_n;
				dot_ok_q   <= dot_ok_n;
				alnum_q    <= alnum_n;
				cnt_q      <= cnt_n;
			end
		end
	end

endmodule
